// ===== hdl/telemetry_frame_encoder_macros.svh =====
// Assertion macros shared by the telemetry frame encoder modules.
`ifndef TELEMETRY_FRAME_ENCODER_MACROS_SVH
`define TELEMETRY_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define TFE_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define TFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tfe_pkg.sv =====
// Types and constants shared by the telemetry frame encoder.
package tfe_pkg;

    localparam int unsigned PAYLOAD_BYTES = 13;
    localparam int unsigned PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
    localparam int unsigned S_DATA_BITS   = 144;
    localparam int unsigned M_DATA_BITS   = 8;

    localparam logic [1:0] CMD_SIX_WORDS   = 2'd0;
    localparam logic [1:0] CMD_THREE_WORDS = 2'd1;
    localparam logic [1:0] CMD_LONG        = 2'd2;

    localparam logic [7:0] FRAME_HEADER   = 8'hAA;
    localparam logic [7:0] FRAME_ADDRESS  = 8'hFF;
    localparam logic [7:0] ID_SIX_WORDS   = 8'h01;
    localparam logic [7:0] ID_THREE_WORDS = 8'h03;
    localparam logic [7:0] ID_LONG        = 8'hF1;

    localparam logic [3:0] LEN_SIX_WORDS   = 4'd13;
    localparam logic [3:0] LEN_THREE_WORDS = 4'd7;
    localparam logic [3:0] LEN_LONG        = 4'd8;

    localparam logic [3:0] HEAD_LAST = 4'd3;

    typedef struct packed {
        logic [7:0]              id;
        logic [3:0]              len;
        logic [PAYLOAD_BITS-1:0] payload;
    } frame_entry_t;

    typedef struct packed {
        logic         valid;
        frame_entry_t entry;
    } queue_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PAYLOAD,
        ST_CHECK1,
        ST_CHECK2
    } back_state_t;

endpackage

// ===== hdl/tfe_front.sv =====
// Front end: accepts records, classifies the command and builds a frame entry.
module tfe_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tfe_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                           push_valid,
    input  logic                           push_ready,
    output tfe_pkg::frame_entry_t          push_entry
);
    import tfe_pkg::*;

    logic [1:0]  command;
    logic [15:0] word_0;
    logic [15:0] word_1;
    logic [15:0] word_2;
    logic [15:0] word_3;
    logic [15:0] word_4;
    logic [15:0] word_5;
    logic [31:0] long_value;
    logic [7:0]  tail_byte;
    logic        known;

    assign command    = s_tdata[1:0];
    assign word_0     = s_tdata[17:2];
    assign word_1     = s_tdata[33:18];
    assign word_2     = s_tdata[49:34];
    assign word_3     = s_tdata[65:50];
    assign word_4     = s_tdata[81:66];
    assign word_5     = s_tdata[97:82];
    assign long_value = s_tdata[129:98];
    assign tail_byte  = s_tdata[137:130];

    always_comb begin
        known = 1'b1;
        push_entry.id = ID_SIX_WORDS;
        push_entry.len = LEN_SIX_WORDS;
        push_entry.payload = {tail_byte, word_5, word_4, word_3, word_2, word_1, word_0};
        case (command)
            CMD_SIX_WORDS: begin
            end
            CMD_THREE_WORDS: begin
                push_entry.id = ID_THREE_WORDS;
                push_entry.len = LEN_THREE_WORDS;
                push_entry.payload = {48'h0, tail_byte, long_value[15:0], word_1, word_0};
            end
            CMD_LONG: begin
                push_entry.id = ID_LONG;
                push_entry.len = LEN_LONG;
                push_entry.payload = {40'h0, long_value, word_1, word_0};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // An unused command is taken from the stream and dropped.
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && known;

endmodule

// ===== hdl/tfe_queue.sv =====
// Short queue of frame entries between the front and back ends.
module tfe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tfe_pkg::frame_entry_t push_entry,
    output logic                  push_ready,
    input  logic                  pop,
    output tfe_pkg::queue_head_t  head
);
    import tfe_pkg::*;

    `include "telemetry_frame_encoder_macros.svh"

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    frame_entry_t  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign push_ready  = (count_reg != CW'(DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `TFE_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count exceeds depth")
    `TFE_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CW'(1), "push lost")
    `TFE_ASSERT_HOLDS(a_pop_nonempty, pop, count_reg != '0, "pop from an empty queue")

endmodule

// ===== hdl/tfe_back.sv =====
// Back end: serializes a frame entry into bytes and computes the two check bytes.
module tfe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tfe_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import tfe_pkg::*;

    `include "telemetry_frame_encoder_macros.svh"

    back_state_t             state_reg, state_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [7:0]              id_reg, id_next;
    logic [3:0]              len_reg, len_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [7:0]              rs_reg, rs_next;
    logic [7:0]              ss_reg, ss_next;
    logic                    m_tvalid_reg;
    logic [7:0]              m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    adv;
    logic                    out_load;
    logic                    summed;
    logic [7:0]              out_byte;
    logic                    out_last;
    logic [7:0]              rs_sum;
    logic                    len_legal;
    logic                    frame_end;

    assign adv = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        id_reg      <= id_next;
        len_reg     <= len_next;
        payload_reg <= payload_next;
        rs_reg      <= rs_next;
        ss_reg      <= ss_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        payload_next = payload_reg;
        rs_next      = rs_reg;
        ss_next      = ss_reg;
        pop          = 1'b0;
        out_load     = 1'b0;
        summed       = 1'b0;
        out_byte     = 8'h00;
        out_last     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop          = 1'b1;
                    id_next      = head.entry.id;
                    len_next     = head.entry.len;
                    payload_next = head.entry.payload;
                    cnt_next     = '0;
                    rs_next      = '0;
                    ss_next      = '0;
                    state_next   = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (adv) begin
                    out_load = 1'b1;
                    summed   = 1'b1;
                    case (cnt_reg[1:0])
                        2'd0:    out_byte = FRAME_HEADER;
                        2'd1:    out_byte = FRAME_ADDRESS;
                        2'd2:    out_byte = id_reg;
                        default: out_byte = {4'h0, len_reg};
                    endcase
                    if (cnt_reg == HEAD_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_PAYLOAD;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (adv) begin
                    out_load     = 1'b1;
                    summed       = 1'b1;
                    out_byte     = payload_reg[7:0];
                    payload_next = payload_reg >> 8;
                    cnt_next     = cnt_reg + 4'd1;
                    if (cnt_reg == len_reg - 4'd1) begin
                        state_next = ST_CHECK1;
                    end
                end
            end
            ST_CHECK1: begin
                if (adv) begin
                    out_load   = 1'b1;
                    out_byte   = rs_reg;
                    state_next = ST_CHECK2;
                end
            end
            ST_CHECK2: begin
                if (adv) begin
                    out_load = 1'b1;
                    out_byte = ss_reg;
                    out_last = 1'b1;
                    if (head.valid) begin
                        pop          = 1'b1;
                        id_next      = head.entry.id;
                        len_next     = head.entry.len;
                        payload_next = head.entry.payload;
                        cnt_next     = '0;
                        rs_next      = '0;
                        ss_next      = '0;
                        state_next   = ST_HEAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        rs_sum = rs_reg + out_byte;
        if (summed) begin
            rs_next = rs_sum;
            ss_next = ss_reg + rs_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_byte;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign len_legal = len_reg inside {LEN_SIX_WORDS, LEN_THREE_WORDS, LEN_LONG};
    assign frame_end = (state_reg == ST_CHECK2) && out_load;

    `TFE_ASSERT_HOLDS(a_pay_bound, state_reg == ST_PAYLOAD, cnt_reg < len_reg, "payload past length")
    `TFE_ASSERT_NEXT(a_last_mark, frame_end, m_tvalid_reg && m_tlast_reg, "frame end not marked")
    `TFE_ASSERT_HOLDS(a_len_legal, state_reg != ST_IDLE, len_legal, "illegal frame length")

endmodule

// ===== hdl/telemetry_frame_encoder.sv =====
// Telemetry frame encoder: record in, framed byte stream with sum-and-add check out.
// With the back end idle, queue, state and output registers lie between a record and its header.
// Throughput: one byte per cycle while m_tready is high; a frame is 13, 14 or 19 bytes long.
// Queued frames follow without gaps; up to QUEUE_DEPTH records wait between front and back.
// Reset (aresetn low, synchronous) empties the queue and the output register, back end idle.
module telemetry_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command, word_0 .. word_5, long_value, tail_byte, zero pad
    input  logic [tfe_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_byte
    output logic [tfe_pkg::M_DATA_BITS-1:0] m_tdata,
    output logic                            m_tlast
);
    import tfe_pkg::*;

    logic         push_valid;
    logic         push_ready;
    frame_entry_t push_entry;
    logic         pop;
    queue_head_t  head;

    tfe_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    tfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid && push_ready),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head)
    );

    tfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
